// ----- rtl/core/bavg_pkg.sv -----
`timescale 1ns / 1ps
package bavg_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int DIM_W      = 12;
	localparam int POS_W      = 11;
	localparam int SUM_W      = 30;
	localparam int AREA_W     = 23;
	localparam int CFG_IDX_W  = 8;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 8'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] bw;
		logic [DIM_W-1:0] bh;
	} geom_t;

	typedef struct packed {
		logic [SUM_W-1:0] sr;
		logic [SUM_W-1:0] sg;
		logic [SUM_W-1:0] sb;
	} sums_t;

	typedef struct packed {
		logic  blk;
		logic  eol;
		sums_t sums;
	} job_t;

endpackage

// ----- rtl/core/bavg_front.sv -----
`timescale 1ns / 1ps
module bavg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  bavg_pkg::geom_t geom,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  bavg_pkg::pixel_t pix,
	output logic            push,
	output bavg_pkg::job_t  job,
	input  logic            full
);
	import bavg_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_UPD  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	typedef struct packed {
		logic acc;
		logic first;
		logic done;
		logic eol;
	} cls_t;

	logic [1:0]       state_q;
	logic [POS_W-1:0] pix_col_q, pix_row_q, row_in_blk_q, col_in_blk_q, blk_col_q;
	logic [POS_W-1:0] addr_q;
	cls_t             cls, cls_q;
	pixel_t           pix_q;
	sums_t            mem [MAX_WIDTH];
	sums_t            rd_q, base, nsum;
	job_t             job_q;
	logic [DIM_W:0]   col_end, row_end;
	logic             full_col, full_row;
	logic             col_wrap, line_wrap, row_wrap, frame_wrap;
	logic             accept;

	assign pix_ready = (state_q == F_IDLE);
	assign accept    = pix_valid && pix_ready;
	assign push      = (state_q == F_PUSH) && !full;
	assign job       = job_q;

	always_comb begin
		col_end   = {2'b0, pix_col_q - col_in_blk_q} + {1'b0, geom.bw};
		row_end   = {2'b0, pix_row_q - row_in_blk_q} + {1'b0, geom.bh};
		full_col  = col_end <= {1'b0, geom.w};
		full_row  = row_end <= {1'b0, geom.h};
		cls.acc   = full_row && full_col;
		cls.first = (row_in_blk_q == '0) && (col_in_blk_q == '0);
		cls.done  = ({1'b0, col_in_blk_q} >= geom.bw - DIM_W'(1))
			&& ({1'b0, row_in_blk_q} >= geom.bh - DIM_W'(1));
		cls.eol   = full_row && ({1'b0, pix_col_q} >= geom.w - DIM_W'(1))
			&& ({1'b0, row_in_blk_q} >= geom.bh - DIM_W'(1));
		col_wrap   = ({1'b0, col_in_blk_q} + DIM_W'(1)) >= geom.bw;
		line_wrap  = ({1'b0, pix_col_q} + DIM_W'(1)) >= geom.w;
		row_wrap   = ({1'b0, row_in_blk_q} + DIM_W'(1)) >= geom.bh;
		frame_wrap = ({1'b0, pix_row_q} + DIM_W'(1)) >= geom.h;
	end

	// The first pixel of a block starts from zero, so stale sums are never seen.
	always_comb begin
		base    = cls_q.first ? '0 : rd_q;
		nsum.sr = base.sr + SUM_W'(pix_q.red);
		nsum.sg = base.sg + SUM_W'(pix_q.green);
		nsum.sb = base.sb + SUM_W'(pix_q.blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			pix_col_q    <= '0;
			pix_row_q    <= '0;
			row_in_blk_q <= '0;
			col_in_blk_q <= '0;
			blk_col_q    <= '0;
		end else if (restart) begin
			state_q      <= F_IDLE;
			pix_col_q    <= '0;
			pix_row_q    <= '0;
			row_in_blk_q <= '0;
			col_in_blk_q <= '0;
			blk_col_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (pix_valid) begin
						state_q <= F_UPD;
						if (line_wrap) begin
							pix_col_q    <= '0;
							col_in_blk_q <= '0;
							blk_col_q    <= '0;
							if (frame_wrap) begin
								pix_row_q    <= '0;
								row_in_blk_q <= '0;
							end else begin
								pix_row_q    <= pix_row_q + POS_W'(1);
								row_in_blk_q <= row_wrap ? '0 : row_in_blk_q + POS_W'(1);
							end
						end else begin
							pix_col_q <= pix_col_q + POS_W'(1);
							if (col_wrap) begin
								col_in_blk_q <= '0;
								blk_col_q    <= blk_col_q + POS_W'(1);
							end else begin
								col_in_blk_q <= col_in_blk_q + POS_W'(1);
							end
						end
					end
				end
				F_UPD: begin
					state_q <= ((cls_q.acc && cls_q.done) || cls_q.eol) ? F_PUSH : F_IDLE;
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= pix;
			cls_q  <= cls;
			addr_q <= blk_col_q;
			rd_q   <= mem[blk_col_q];
		end
		if (state_q == F_UPD) begin
			if (cls_q.acc) begin
				mem[addr_q] <= cls_q.done ? '0 : nsum;
			end
			job_q.blk  <= cls_q.acc && cls_q.done;
			job_q.eol  <= cls_q.eol;
			job_q.sums <= nsum;
		end
	end

endmodule

// ----- rtl/core/bavg_fifo.sv -----
`timescale 1ns / 1ps
module bavg_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bavg_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output bavg_pkg::job_t dout
);
	import bavg_pkg::*;

	job_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign dout     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> nonempty)
		else $error("Queue read while empty.");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(FIFO_DEPTH))
		else $error("Queue fill count out of range.");

endmodule

// ----- rtl/core/bavg_back.sv -----
`timescale 1ns / 1ps
module bavg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [bavg_pkg::AREA_W-1:0] area,
	input  logic                        job_valid,
	input  bavg_pkg::job_t              job,
	output logic                        pop,
	output logic                        res_valid,
	input  logic                        res_ready,
	output bavg_pkg::result_t           res
);
	import bavg_pkg::*;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_DIV  = 4'd1;
	localparam logic [3:0] B_CMP  = 4'd2;
	localparam logic [3:0] B_PFX  = 4'd3;
	localparam logic [3:0] B_DIG  = 4'd4;
	localparam logic [3:0] B_SEP  = 4'd5;
	localparam logic [3:0] B_DEF  = 4'd6;
	localparam logic [3:0] B_SP   = 4'd7;
	localparam logic [3:0] B_EOL  = 4'd8;
	localparam logic [3:0] B_EDEF = 4'd9;
	localparam logic [3:0] B_NL   = 4'd10;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_4    = 8'h34;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_NL   = 8'h0A;

	localparam logic [7:0] SET_SEQ [7] = '{CH_ESC, CH_LBR, CH_4, CH_8, CH_SEMI, CH_2, CH_SEMI};
	localparam logic [7:0] DEF_SEQ [4] = '{CH_ESC, CH_LBR, CH_0, CH_M};

	typedef struct packed {
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
		logic [1:0] n;
	} dec_t;

	// Division by ten is a multiply by 205 and a shift, exact for these ranges.
	function automatic dec_t to_dec(input logic [7:0] v);
		logic [15:0] p1;
		logic [4:0]  q1;
		logic [12:0] p2;
		logic [1:0]  q2;
		dec_t        d;
		p1   = {8'b0, v} * 16'd205;
		q1   = p1[15:11];
		p2   = {8'b0, q1} * 13'd205;
		q2   = p2[12:11];
		d.d0 = 4'(v - 8'(q1 * 8'd10));
		d.d1 = 4'(q1 - 5'(q2 * 5'd10));
		d.d2 = {2'b0, q2};
		d.n  = (q2 != '0) ? 2'd3 : ((q1 != '0) ? 2'd2 : 2'd1);
		return d;
	endfunction

	logic [3:0]       state_q;
	logic             eol_q;
	logic [SUM_W-1:0] rem_q [3];
	logic [7:0]       quo_q [3];
	logic [2:0]       step_q;
	logic [23:0]      prev_q;
	dec_t             dig_q [3];
	logic [1:0]       ch_q;
	logic [2:0]       pos_q;
	result_t          res_q;
	logic             res_valid_q;
	logic             free, emitting, emit;
	logic [7:0]       byte_c;
	logic             last_c;
	logic [3:0]       digit_c;
	logic [SUM_W-1:0] cand;
	logic [23:0]      avg;

	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign free      = !res_valid_q || res_ready;
	assign pop       = (state_q == B_IDLE) && job_valid;
	assign cand      = SUM_W'(area) << step_q;
	assign avg       = {quo_q[0], quo_q[1], quo_q[2]};

	always_comb begin
		unique case (pos_q)
			3'd0:    digit_c = dig_q[ch_q].d0;
			3'd1:    digit_c = dig_q[ch_q].d1;
			default: digit_c = dig_q[ch_q].d2;
		endcase
	end

	always_comb begin
		emitting = 1'b1;
		last_c   = 1'b0;
		byte_c   = CH_SP;
		unique case (state_q)
			B_PFX:  byte_c = SET_SEQ[pos_q];
			B_DIG:  byte_c = CH_0 + {4'b0, digit_c};
			B_SEP:  byte_c = (ch_q == 2'd2) ? CH_M : CH_SEMI;
			B_DEF:  byte_c = DEF_SEQ[pos_q[1:0]];
			B_EDEF: byte_c = DEF_SEQ[pos_q[1:0]];
			B_SP: begin
				byte_c = CH_SP;
				last_c = !eol_q;
			end
			B_NL: begin
				byte_c = CH_NL;
				last_c = 1'b1;
			end
			default: emitting = 1'b0;
		endcase
	end

	assign emit = emitting && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			prev_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (restart) begin
			state_q     <= B_IDLE;
			prev_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= job.blk ? B_DIV : B_EOL;
					end
				end
				B_DIV: begin
					if (step_q == '0) begin
						state_q <= B_CMP;
					end
				end
				B_CMP: begin
					if (avg != prev_q) begin
						prev_q  <= avg;
						state_q <= (avg != '0) ? B_PFX : B_DEF;
					end else begin
						state_q <= B_SP;
					end
				end
				B_PFX: begin
					if (free && pos_q == 3'd6) begin
						state_q <= B_DIG;
					end
				end
				B_DIG: begin
					if (free && pos_q == '0) begin
						state_q <= B_SEP;
					end
				end
				B_SEP: begin
					if (free) begin
						state_q <= (ch_q == 2'd2) ? B_SP : B_DIG;
					end
				end
				B_DEF: begin
					if (free && pos_q == 3'd3) begin
						state_q <= B_SP;
					end
				end
				B_SP: begin
					if (free) begin
						state_q <= eol_q ? B_EOL : B_IDLE;
					end
				end
				B_EOL: begin
					if (prev_q != '0) begin
						prev_q  <= '0;
						state_q <= B_EDEF;
					end else begin
						state_q <= B_NL;
					end
				end
				B_EDEF: begin
					if (free && pos_q == 3'd3) begin
						state_q <= B_NL;
					end
				end
				B_NL: begin
					if (free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_byte <= byte_c;
			res_q.last     <= last_c;
		end
		unique case (state_q)
			B_IDLE: begin
				eol_q    <= job.eol;
				rem_q[0] <= job.sums.sr;
				rem_q[1] <= job.sums.sg;
				rem_q[2] <= job.sums.sb;
				step_q   <= 3'd7;
				pos_q    <= '0;
			end
			B_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (rem_q[i] >= cand) begin
						rem_q[i] <= rem_q[i] - cand;
						quo_q[i] <= {quo_q[i][6:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][6:0], 1'b0};
					end
				end
				step_q <= step_q - 3'd1;
			end
			B_CMP: begin
				for (int i = 0; i < 3; i++) begin
					dig_q[i] <= to_dec(quo_q[i]);
				end
				ch_q  <= '0;
				pos_q <= '0;
			end
			B_PFX: begin
				if (free) begin
					pos_q <= (pos_q == 3'd6) ? 3'(dig_q[0].n - 2'd1) : pos_q + 3'd1;
				end
			end
			B_DIG: begin
				if (free && pos_q != '0) begin
					pos_q <= pos_q - 3'd1;
				end
			end
			B_SEP: begin
				if (free && ch_q != 2'd2) begin
					ch_q  <= ch_q + 2'd1;
					pos_q <= 3'(dig_q[ch_q + 2'd1].n - 2'd1);
				end
			end
			B_DEF, B_EDEF: begin
				if (free) begin
					pos_q <= (pos_q == 3'd3) ? '0 : pos_q + 3'd1;
				end
			end
			B_EOL: begin
				pos_q <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/core/block_average_ansi_color_render_top.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// pixel    | in        | pix_valid / pix_ready | pix (red, green, blue)
// result   | out       | res_valid / res_ready | res (out_byte, last)
//
// The front end accepts a pixel, then updates the sums; at the end of a block or block
// row it also queues a job, waiting while the queue is full, before the next pixel.
// Each completed block takes a queue read, the shared restoring divider, a compare and
// then its output bytes, held while the result side stalls; an end of block row adds a
// color reset check and its bytes.
// There is no clearing pass: the first pixel of every block starts its sums at zero.
// A two-entry queue lets the pixel side run on while the byte stream is stalled.
module block_average_ansi_color_render_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bavg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bavg_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  bavg_pkg::pixel_t               pix,
	output logic                           res_valid,
	input  logic                           res_ready,
	output bavg_pkg::result_t              res
);
	import bavg_pkg::*;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	logic [DIM_W-1:0]  img_w_q, img_h_q, blk_w_q, blk_h_q;
	logic [AREA_W-1:0] area_q;
	geom_t             geom;
	logic              restart;
	logic              push, full, pop, nonempty;
	job_t              job_in, job_out;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH
		|| cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_BLOCK_WIDTH
		|| cfg_index == REG_BLOCK_HEIGHT);

	assign geom.w  = clamp_dim(img_w_q, DIM_W'(MAX_WIDTH));
	assign geom.h  = clamp_dim(img_h_q, DIM_W'(MAX_HEIGHT));
	assign geom.bw = clamp_dim(blk_w_q, DIM_W'(MAX_WIDTH));
	assign geom.bh = clamp_dim(blk_h_q, DIM_W'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= DIM_W'(1);
			img_h_q <= DIM_W'(1);
			blk_w_q <= DIM_W'(1);
			blk_h_q <= DIM_W'(1);
			area_q  <= AREA_W'(1);
		end else begin
			area_q <= AREA_W'({12'b0, geom.bw} * {12'b0, geom.bh});
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
					REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
					REG_BLOCK_WIDTH:  blk_w_q <= cfg_data;
					REG_BLOCK_HEIGHT: blk_h_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	bavg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.geom      (geom),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.push      (push),
		.job       (job_in),
		.full      (full)
	);

	bavg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (job_in),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.dout     (job_out)
	);

	bavg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.area      (area_q),
		.job_valid (nonempty),
		.job       (job_out),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ----- sim/tb_block_average_ansi_color_render_top.sv -----
`timescale 1ns / 1ps
module tb_block_average_ansi_color_render_top;
	import bavg_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 80;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pixel_t pix = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	result_t res;

	pixel_t pending_pixels[$];
	result_t expected_bytes[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int errors = 0;
	int cycles = 0;

	logic [DIM_W-1:0] reg_w, reg_h, reg_bw, reg_bh;
	int unsigned acc_r[MAX_WIDTH];
	int unsigned acc_g[MAX_WIDTH];
	int unsigned acc_b[MAX_WIDTH];
	logic [23:0] shown_color;
	int col, row, blk_row, blk_col, blk_idx;

	block_average_ansi_color_render_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic restart_frame();
		for (int i = 0; i < MAX_WIDTH; i++) begin
			acc_r[i] = 0;
			acc_g[i] = 0;
			acc_b[i] = 0;
		end
		shown_color = '0;
		col = 0;
		row = 0;
		blk_row = 0;
		blk_col = 0;
		blk_idx = 0;
	endtask

	task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
		case (idx)
			REG_IMAGE_WIDTH: reg_w = v;
			REG_IMAGE_HEIGHT: reg_h = v;
			REG_BLOCK_WIDTH: reg_bw = v;
			REG_BLOCK_HEIGHT: reg_bh = v;
			default: return;
		endcase
		restart_frame();
	endtask

	task automatic push_decimal(ref logic [7:0] q[$], input logic [7:0] v);
		if (v >= 100) q.push_back(CH_ZERO + v / 100);
		if (v >= 10) q.push_back(CH_ZERO + (v / 10) % 10);
		q.push_back(CH_ZERO + v % 10);
	endtask

	task automatic render_pixel(pixel_t p);
		int unsigned w, h, bw, bh, area;
		logic [7:0] r, g, b;
		logic [23:0] avg;
		logic [7:0] bytes[$];
		result_t item;
		bit full_row;
		w = clamp_dim(reg_w, MAX_WIDTH);
		h = clamp_dim(reg_h, MAX_HEIGHT);
		bw = clamp_dim(reg_bw, MAX_WIDTH);
		bh = clamp_dim(reg_bh, MAX_HEIGHT);
		full_row = row < (h / bh) * bh;
		if (full_row && blk_idx < w / bw) begin
			acc_r[blk_idx] += p.red;
			acc_g[blk_idx] += p.green;
			acc_b[blk_idx] += p.blue;
			if (blk_col >= bw - 1 && blk_row >= bh - 1) begin
				area = bw * bh;
				r = 8'(acc_r[blk_idx] / area);
				g = 8'(acc_g[blk_idx] / area);
				b = 8'(acc_b[blk_idx] / area);
				avg = {r, g, b};
				acc_r[blk_idx] = 0;
				acc_g[blk_idx] = 0;
				acc_b[blk_idx] = 0;
				if (avg != shown_color) begin
					if (avg != 0) begin
						bytes = {CH_ESC, CH_BRACKET, 8'h34, 8'h38, CH_SEMI, 8'h32, CH_SEMI};
						push_decimal(bytes, r);
						bytes.push_back(CH_SEMI);
						push_decimal(bytes, g);
						bytes.push_back(CH_SEMI);
						push_decimal(bytes, b);
						bytes.push_back(CH_M);
					end else begin
						bytes = {CH_ESC, CH_BRACKET, CH_ZERO, CH_M};
					end
					shown_color = avg;
				end
				bytes.push_back(CH_SPACE);
			end
		end
		if (full_row && col >= w - 1 && blk_row >= bh - 1) begin
			if (shown_color != 0) begin
				bytes.push_back(CH_ESC);
				bytes.push_back(CH_BRACKET);
				bytes.push_back(CH_ZERO);
				bytes.push_back(CH_M);
				shown_color = '0;
			end
			bytes.push_back(CH_NL);
		end
		blk_col++;
		if (blk_col >= bw) begin
			blk_col = 0;
			blk_idx++;
		end
		col++;
		if (col >= w) begin
			col = 0;
			blk_col = 0;
			blk_idx = 0;
			blk_row++;
			if (blk_row >= bh) blk_row = 0;
			row++;
			if (row >= h) begin
				row = 0;
				blk_row = 0;
			end
		end
		foreach (bytes[i]) begin
			item.out_byte = bytes[i];
			item.last = (i == bytes.size() - 1);
			expected_bytes.push_back(item);
		end
	endtask

	task automatic report(string what, result_t got, result_t want);
		errors++;
		$display("byte mismatch (%s): got %02h/%0d, wanted %02h/%0d", what,
			got.out_byte, got.last, want.out_byte, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (!pix_valid || pix_ready) begin
			if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
				pix <= pending_pixels.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
		res_ready <= arst_n && hold_cycles <= 1 && $urandom_range(99) >= stall_pct;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
			if (pix_valid && pix_ready) render_pixel(pix);
			if (res_valid && res_ready) begin
				if (expected_bytes.size() == 0) begin
					report("unexpected", res, '0);
				end else begin
					want = expected_bytes.pop_front();
					if (res.out_byte != want.out_byte) report("out_byte", res, want);
					else if (res.last != want.last) report("last", res, want);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_block_average_ansi_color_render_top: errors");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int w, int h, int bw, int bh);
		write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
		write_reg(REG_BLOCK_WIDTH, DIM_W'(bw));
		write_reg(REG_BLOCK_HEIGHT, DIM_W'(bh));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_pixels.size() > 0 || pix_valid || expected_bytes.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_pixel(int r, int g, int b);
		pixel_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		pending_pixels.push_back(p);
	endtask

	task automatic queue_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(5);
			case (pick)
				0: queue_pixel(0, 0, 0);
				1: queue_pixel(255, 255, 255);
				2: queue_pixel(10, 200, 3);
				default: queue_pixel($urandom_range(255), $urandom_range(255),
					$urandom_range(255));
			endcase
		end
	endtask

	initial begin
		reg_w = 1;
		reg_h = 1;
		reg_bw = 1;
		reg_bh = 1;
		restart_frame();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 255);
		queue_pixel(255, 255, 255);
		queue_pixel(0, 0, 1);
		queue_pixel(9, 10, 99);
		queue_pixel(100, 255, 0);
		queue_pixel(0, 0, 0);
		queue_pixel(0, 0, 0);
		queue_pixel(170, 85, 170);
		queue_pixel(85, 170, 85);
		queue_pixel(1, 0, 0);
		queue_pixel(0, 1, 0);
		drain();

		configure(4, 4, 2, 2);
		queue_pixel(255, 255, 255);
		queue_pixel(255, 255, 255);
		queue_pixel(0, 0, 0);
		queue_pixel(0, 0, 0);
		queue_pixel(255, 255, 254);
		queue_pixel(255, 255, 255);
		queue_pixel(0, 0, 0);
		queue_pixel(0, 0, 3);
		queue_random(64);
		drain();

		idle_pct = 65;
		configure(7, 5, 3, 2);
		queue_random(70);
		drain();

		idle_pct = 0;
		configure(3, 2, 5, 1);
		queue_random(12);
		drain();
		configure(4095, 4095, 4095, 4095);
		queue_random(20);
		drain();

		stall_pct = 65;
		configure(0, 0, 0, 0);
		write_reg(REG_NONE, DIM_W'(4095));
		queue_random(40);
		drain();

		stall_pct = 0;
		configure(5, 4, 1, 2);
		hold_cycles <= 600;
		queue_random(60);
		drain();

		idle_pct = 34;
		stall_pct = 34;
		configure(8, 6, 2, 3);
		queue_random(48);
		drain();
		queue_random(48);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		configure(6, 4, 1, 1);
		queue_random(48);
		drain();

		if (errors == 0) begin
			$display("tb_block_average_ansi_color_render_top: clean");
		end else begin
			$display("tb_block_average_ansi_color_render_top: errors");
		end
		$finish;
	end
endmodule
